[design/rep_pkg.sv]
`timescale 1ns / 1ps

package rep_pkg;

   localparam int ANGLE_BITS_DEF = 16;
   localparam int CSR_ADDR_BITS = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int CORDIC_STEPS = 24;
   localparam int SQRT_STEPS = 32;
   localparam int NUM_BITS = 45;

   localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

   localparam logic signed [31:0] ATAN_TURN [CORDIC_STEPS] = '{
      32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
      32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
      32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772,
      32'sd166886, 32'sd83443, 32'sd41722, 32'sd20861,
      32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304,
      32'sd652, 32'sd326, 32'sd163, 32'sd81
   };

   localparam logic signed [15:0] TRIG_ONE = 16'sd16384;
   localparam logic [16:0] OUT_LIMIT = 17'd65536;

   localparam logic [15:0] AXIS_A_RESET = 16'd0;
   localparam logic [15:0] AXIS_B_RESET = 16'd0;
   localparam logic signed [15:0] ROT_COS_RESET = 16'sd2280;
   localparam logic signed [15:0] ROT_SIN_RESET = 16'sd16225;

   typedef enum logic [1:0] {
      REG_AXIS_A  = 2'd0,
      REG_AXIS_B  = 2'd1,
      REG_ROT_COS = 2'd2,
      REG_ROT_SIN = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      QUAD_0   = 2'd0,
      QUAD_90  = 2'd1,
      QUAD_180 = 2'd2,
      QUAD_270 = 2'd3
   } quad_type;

   typedef struct packed {
      quad_type          quad;
      logic signed [31:0] resid;
   } item_type;

   typedef struct packed {
      logic signed [15:0] cos_v;
      logic signed [15:0] sin_v;
   } trig_type;

   typedef struct packed {
      logic [15:0]        axis_a;
      logic [15:0]        axis_b;
      logic signed [15:0] rot_cos;
      logic signed [15:0] rot_sin;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

[design/rep_front.sv]
`timescale 1ns / 1ps

module rep_front #(
   parameter int ANGLE_BITS = rep_pkg::ANGLE_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [15:0]         angle,
   output logic                full,
   input  rep_pkg::qstat_type  q_stat,
   output logic                q_push,
   output rep_pkg::item_type   q_item
);

   logic               fr_valid_ff;
   logic               fr_valid_in;
   rep_pkg::item_type  fr_item_ff;
   rep_pkg::item_type  fr_item_in;
   logic               accept;
   logic [31:0]        ang_ext;
   logic [31:0]        phase;
   logic [31:0]        bias;
   rep_pkg::quad_type  quad;
   logic [31:0]        resid;

   // turn fraction, nearest quarter turn and signed residual
   assign ang_ext = {16'b0, angle};
   assign phase   = ang_ext << (32 - ANGLE_BITS);
   assign bias    = phase + 32'h2000_0000;
   assign quad    = rep_pkg::quad_type'(bias[31:30]);
   assign resid   = phase - {quad, 30'b0};

   assign full   = fr_valid_ff && q_stat.full;
   assign q_push = fr_valid_ff && !q_stat.full;
   assign q_item = fr_item_ff;
   assign accept = push && !full;

   always_comb begin
      fr_valid_in = fr_valid_ff;
      fr_item_in  = fr_item_ff;
      if (accept) begin
         fr_valid_in      = 1'b1;
         fr_item_in.quad  = quad;
         fr_item_in.resid = $signed(resid);
      end else if (q_push) begin
         fr_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else begin
         fr_valid_ff <= fr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fr_item_ff <= fr_item_in;
   end

endmodule

[design/rep_fifo.sv]
`timescale 1ns / 1ps

module rep_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rep_pkg::item_type  wr_item,
   input  logic               pop,
   output rep_pkg::item_type  rd_item,
   output rep_pkg::qstat_type stat
);

   localparam int Depth = rep_pkg::QUEUE_DEPTH;
   localparam int PtrBits = $clog2(Depth);
   localparam int CntBits = $clog2(Depth + 1);

   rep_pkg::item_type  slot_ff [Depth];
   logic [PtrBits-1:0] wr_ptr_ff;
   logic [PtrBits-1:0] wr_ptr_in;
   logic [PtrBits-1:0] rd_ptr_ff;
   logic [PtrBits-1:0] rd_ptr_in;
   logic [CntBits-1:0] count_ff;
   logic [CntBits-1:0] count_in;
   logic               do_push;
   logic               do_pop;

   assign stat.full  = (count_ff == CntBits'(Depth));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign rd_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

[design/rep_cordic.sv]
`timescale 1ns / 1ps

module rep_cordic (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  rep_pkg::item_type in_item,
   output logic              out_valid,
   output rep_pkg::trig_type out_trig
);

   localparam int Steps = rep_pkg::CORDIC_STEPS;

   logic               cv_ff [Steps+1];
   logic signed [33:0] cx_ff [Steps+1];
   logic signed [33:0] cy_ff [Steps+1];
   logic signed [31:0] cz_ff [Steps+1];
   rep_pkg::quad_type  cq_ff [Steps+1];
   logic signed [33:0] cx_in [Steps+1];
   logic signed [33:0] cy_in [Steps+1];
   logic signed [31:0] cz_in [Steps+1];

   logic               tv_ff;
   rep_pkg::trig_type  tr_ff;
   rep_pkg::trig_type  tr_in;
   logic signed [34:0] xr;
   logic signed [34:0] yr;
   logic signed [15:0] cz_q;
   logic signed [15:0] sz_q;

   function automatic logic signed [15:0] clamp_trig(input logic signed [18:0] v);
      logic signed [15:0] r;
      if (v > 19'sd16384) begin
         r = rep_pkg::TRIG_ONE;
      end else if (v < -19'sd16384) begin
         r = -rep_pkg::TRIG_ONE;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= 1'b0;
      end else if (adv) begin
         cv_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cx_ff[0] <= rep_pkg::CORDIC_X0;
         cy_ff[0] <= '0;
         cz_ff[0] <= in_item.resid;
         cq_ff[0] <= in_item.quad;
      end
   end

   for (genvar i = 0; i < Steps; i++) begin : g_rot
      assign cx_in[i+1] = cz_ff[i][31] ? cx_ff[i] + (cy_ff[i] >>> i)
                                       : cx_ff[i] - (cy_ff[i] >>> i);
      assign cy_in[i+1] = cz_ff[i][31] ? cy_ff[i] - (cx_ff[i] >>> i)
                                       : cy_ff[i] + (cx_ff[i] >>> i);
      assign cz_in[i+1] = cz_ff[i][31] ? cz_ff[i] + rep_pkg::ATAN_TURN[i]
                                       : cz_ff[i] - rep_pkg::ATAN_TURN[i];

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[i+1] <= 1'b0;
         end else if (adv) begin
            cv_ff[i+1] <= cv_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cx_ff[i+1] <= cx_in[i+1];
            cy_ff[i+1] <= cy_in[i+1];
            cz_ff[i+1] <= cz_in[i+1];
            cq_ff[i+1] <= cq_ff[i];
         end
      end
   end

   assign cx_in[0] = rep_pkg::CORDIC_X0;
   assign cy_in[0] = '0;
   assign cz_in[0] = in_item.resid;

   // round to q1.14 and turn by the quarter
   assign xr   = 35'(cx_ff[Steps]) + 35'sd32768;
   assign yr   = 35'(cy_ff[Steps]) + 35'sd32768;
   assign cz_q = clamp_trig(xr[34:16]);
   assign sz_q = clamp_trig(yr[34:16]);

   always_comb begin
      case (cq_ff[Steps])
         rep_pkg::QUAD_0: begin
            tr_in.cos_v = cz_q;
            tr_in.sin_v = sz_q;
         end
         rep_pkg::QUAD_90: begin
            tr_in.cos_v = -sz_q;
            tr_in.sin_v = cz_q;
         end
         rep_pkg::QUAD_180: begin
            tr_in.cos_v = -cz_q;
            tr_in.sin_v = -sz_q;
         end
         default: begin
            tr_in.cos_v = sz_q;
            tr_in.sin_v = -cz_q;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tv_ff <= 1'b0;
      end else if (adv) begin
         tv_ff <= cv_ff[Steps];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tr_ff <= tr_in;
      end
   end

   assign out_valid = tv_ff;
   assign out_trig  = tr_ff;

endmodule

[design/rep_radius.sv]
`timescale 1ns / 1ps

module rep_radius (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  rep_pkg::trig_type  in_trig,
   input  rep_pkg::cfg_type   cfg,
   output logic               out_valid,
   output logic signed [17:0] point_x,
   output logic signed [17:0] point_y,
   output logic               degenerate
);

   localparam int SqrtSteps = rep_pkg::SQRT_STEPS;
   localparam int NumBits = rep_pkg::NUM_BITS;

   // rotation products
   logic               v1_ff;
   rep_pkg::trig_type  t1_ff;
   logic signed [31:0] pcc_ff, pss_ff, psc_ff, pcs_ff;

   // |cd| and |sd|
   logic               v2_ff;
   rep_pkg::trig_type  t2_ff;
   logic signed [33:0] cd_sum, sd_sum;
   logic signed [19:0] cd_q, sd_q;
   logic [16:0]        acd_ff, acd_in, asd_ff, asd_in;

   // axis terms
   logic               v3_ff;
   rep_pkg::trig_type  t3_ff;
   logic [32:0]        pb, pa;
   logic [33:0]        pb_r, pa_r;
   logic [30:0]        mb_ff, ma_ff;

   // squares
   logic               v4_ff;
   rep_pkg::trig_type  t4_ff;
   logic [61:0]        sqb_ff, sqa_ff;

   // square root pipeline, entry 0 holds the radicand
   logic               sv_ff    [SqrtSteps+1];
   rep_pkg::trig_type  st_ff    [SqrtSteps+1];
   logic [63:0]        srem_ff  [SqrtSteps+1];
   logic [31:0]        sroot_ff [SqrtSteps+1];

   // divider pipeline, entry 0 holds numerator and denominator
   logic               dv_ff   [NumBits+1];
   rep_pkg::trig_type  dt_ff   [NumBits+1];
   logic               dz_ff   [NumBits+1];
   logic [NumBits-1:0] nq_ff   [NumBits+1];
   logic [31:0]        den_ff  [NumBits+1];
   logic [31:0]        drem_ff [NumBits+1];
   logic [31:0]        ab;
   logic [NumBits-1:0] num_in;

   // scale by cos and sin
   logic               v6_ff;
   logic               z6_ff;
   logic               sx_ff, sy_ff;
   logic [46:0]        mx_ff, my_ff;
   logic [NumBits-1:0] rho;
   logic [31:0]        rsat;
   logic [14:0]        acos_v, asin_v;

   // result
   logic               ov_ff;
   logic signed [17:0] px_ff, py_ff, px_in, py_in;
   logic               dg_ff;
   logic [16:0]        magx, magy;

   function automatic logic [16:0] round_clamp(input logic [46:0] m);
      logic [47:0] r;
      logic [33:0] q;
      r = 48'(m) + 48'd8192;
      q = r[47:14];
      return (q > 34'(rep_pkg::OUT_LIMIT)) ? rep_pkg::OUT_LIMIT : q[16:0];
   endfunction

   // stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_ff  <= in_trig;
         pcc_ff <= $signed(in_trig.cos_v) * $signed(cfg.rot_cos);
         pss_ff <= $signed(in_trig.sin_v) * $signed(cfg.rot_sin);
         psc_ff <= $signed(in_trig.sin_v) * $signed(cfg.rot_cos);
         pcs_ff <= $signed(in_trig.cos_v) * $signed(cfg.rot_sin);
      end
   end

   // stage 2
   assign cd_sum = 34'(pcc_ff) + 34'(pss_ff) + 34'sd8192;
   assign sd_sum = 34'(psc_ff) - 34'(pcs_ff) + 34'sd8192;
   assign cd_q   = cd_sum[33:14];
   assign sd_q   = sd_sum[33:14];
   assign acd_in = cd_q[19] ? 17'(-cd_q) : cd_q[16:0];
   assign asd_in = sd_q[19] ? 17'(-sd_q) : sd_q[16:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t2_ff  <= t1_ff;
         acd_ff <= acd_in;
         asd_ff <= asd_in;
      end
   end

   // stage 3
   assign pb   = cfg.axis_b * acd_ff;
   assign pa   = cfg.axis_a * asd_ff;
   assign pb_r = 34'(pb) + 34'd2;
   assign pa_r = 34'(pa) + 34'd2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t3_ff <= t2_ff;
         mb_ff <= pb_r[32:2];
         ma_ff <= pa_r[32:2];
      end
   end

   // stage 4
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t4_ff  <= t3_ff;
         sqb_ff <= mb_ff * mb_ff;
         sqa_ff <= ma_ff * ma_ff;
      end
   end

   // stage 5, radicand
   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff[0] <= 1'b0;
      end else if (adv) begin
         sv_ff[0] <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff[0]    <= t4_ff;
         srem_ff[0]  <= 64'(sqb_ff) + 64'(sqa_ff);
         sroot_ff[0] <= '0;
      end
   end

   // one root bit per stage
   for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
      localparam int K = SqrtSteps - 1 - j;
      logic [63:0] trial;
      logic        take;
      logic [63:0] rem_in;
      logic [31:0] root_in;

      assign trial   = (64'(sroot_ff[j]) << (K + 1)) | (64'd1 << (2 * K));
      assign take    = (srem_ff[j] >= trial);
      assign rem_in  = take ? srem_ff[j] - trial : srem_ff[j];
      assign root_in = take ? (sroot_ff[j] | (32'd1 << K)) : sroot_ff[j];

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[j+1] <= 1'b0;
         end else if (adv) begin
            sv_ff[j+1] <= sv_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[j+1]    <= st_ff[j];
            srem_ff[j+1]  <= rem_in;
            sroot_ff[j+1] <= root_in;
         end
      end
   end

   // numerator with half the denominator for rounding
   assign ab     = cfg.axis_a * cfg.axis_b;
   assign num_in = {1'b0, ab, 12'b0} + NumBits'(sroot_ff[SqrtSteps] >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_ff[0] <= sv_ff[SqrtSteps];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dt_ff[0]   <= st_ff[SqrtSteps];
         dz_ff[0]   <= (sroot_ff[SqrtSteps] == '0);
         nq_ff[0]   <= num_in;
         den_ff[0]  <= sroot_ff[SqrtSteps];
         drem_ff[0] <= '0;
      end
   end

   // one quotient bit per stage, shifted in as numerator bits leave
   for (genvar j = 0; j < NumBits; j++) begin : g_div
      logic [32:0] remsh;
      logic        take;
      logic [32:0] diff;
      logic [31:0] rem_in;

      assign remsh  = {drem_ff[j], nq_ff[j][NumBits-1]};
      assign take   = (remsh >= {1'b0, den_ff[j]});
      assign diff   = remsh - {1'b0, den_ff[j]};
      assign rem_in = take ? diff[31:0] : remsh[31:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j+1] <= 1'b0;
         end else if (adv) begin
            dv_ff[j+1] <= dv_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dt_ff[j+1]   <= dt_ff[j];
            dz_ff[j+1]   <= dz_ff[j];
            nq_ff[j+1]   <= {nq_ff[j][NumBits-2:0], take};
            den_ff[j+1]  <= den_ff[j];
            drem_ff[j+1] <= rem_in;
         end
      end
   end

   // stage 6, saturate rho and scale
   assign rho    = nq_ff[NumBits];
   assign rsat   = (|rho[NumBits-1:31]) ? 32'h8000_0000 : rho[31:0];
   assign acos_v = dt_ff[NumBits].cos_v[15] ? 15'(-dt_ff[NumBits].cos_v)
                                            : dt_ff[NumBits].cos_v[14:0];
   assign asin_v = dt_ff[NumBits].sin_v[15] ? 15'(-dt_ff[NumBits].sin_v)
                                            : dt_ff[NumBits].sin_v[14:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (adv) begin
         v6_ff <= dv_ff[NumBits];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         z6_ff <= dz_ff[NumBits];
         sx_ff <= dt_ff[NumBits].cos_v[15];
         sy_ff <= dt_ff[NumBits].sin_v[15];
         mx_ff <= rsat * acos_v;
         my_ff <= rsat * asin_v;
      end
   end

   // stage 7, round, clamp and sign
   assign magx = round_clamp(mx_ff);
   assign magy = round_clamp(my_ff);

   always_comb begin
      if (z6_ff) begin
         px_in = '0;
         py_in = '0;
      end else begin
         px_in = sx_ff ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
         py_in = sy_ff ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (adv) begin
         ov_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff <= px_in;
         py_ff <= py_in;
         dg_ff <= z6_ff;
      end
   end

   assign out_valid  = ov_ff;
   assign point_x    = px_ff;
   assign point_y    = py_ff;
   assign degenerate = dg_ff;

endmodule

[design/rotated_ellipse_polar_point.sv]
`timescale 1ns / 1ps

// channel   ports                                   direction
// req       req_push, req_full, req_angle           in
// rsp       rsp_pop, rsp_empty, rsp_point_x/_y,     out
//           rsp_degenerate
// csr       csr_psel .. csr_prdata, csr_pready      apb write/read
//
// one angle per cycle sustained while results are popped without waiting
// the pipeline holds the 24-stage cordic, the 32-stage square root and the
// 45-stage divider, all advancing together when the result register moves
// a four-entry queue after the front stage takes transfers while the back stalls
// synchronous active-high reset clears all valid flags and the queue

module rotated_ellipse_polar_point #(
   parameter int ANGLE_BITS = rep_pkg::ANGLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [15:0]                       req_angle,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic signed [17:0]                rsp_point_x,
   output logic signed [17:0]                rsp_point_y,
   output logic                              rsp_degenerate,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rep_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   rep_pkg::cfg_type       cfg_ff;
   rep_pkg::cfg_type       cfg_in;
   rep_pkg::reg_index_type csr_index;
   logic                   csr_write;

   rep_pkg::qstat_type q_stat;
   logic               q_push;
   rep_pkg::item_type  q_item;
   rep_pkg::item_type  head_item;
   logic               adv;
   logic               q_pop;
   logic               trig_valid;
   rep_pkg::trig_type  trig;
   logic               out_valid;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_index  = rep_pkg::reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            rep_pkg::REG_AXIS_A:  cfg_in.axis_a  = csr_pwdata[15:0];
            rep_pkg::REG_AXIS_B:  cfg_in.axis_b  = csr_pwdata[15:0];
            rep_pkg::REG_ROT_COS: cfg_in.rot_cos = $signed(csr_pwdata[15:0]);
            rep_pkg::REG_ROT_SIN: cfg_in.rot_sin = $signed(csr_pwdata[15:0]);
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.axis_a  <= rep_pkg::AXIS_A_RESET;
         cfg_ff.axis_b  <= rep_pkg::AXIS_B_RESET;
         cfg_ff.rot_cos <= rep_pkg::ROT_COS_RESET;
         cfg_ff.rot_sin <= rep_pkg::ROT_SIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (csr_index)
         rep_pkg::REG_AXIS_A:  csr_prdata = {16'b0, cfg_ff.axis_a};
         rep_pkg::REG_AXIS_B:  csr_prdata = {16'b0, cfg_ff.axis_b};
         rep_pkg::REG_ROT_COS: csr_prdata = 32'(cfg_ff.rot_cos);
         rep_pkg::REG_ROT_SIN: csr_prdata = 32'(cfg_ff.rot_sin);
         default:              csr_prdata = '0;
      endcase
   end

   // front, queue, back
   rep_front #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .push   (req_push),
      .angle  (req_angle),
      .full   (req_full),
      .q_stat (q_stat),
      .q_push (q_push),
      .q_item (q_item)
   );

   rep_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_item (q_item),
      .pop     (q_pop),
      .rd_item (head_item),
      .stat    (q_stat)
   );

   assign adv   = !out_valid || rsp_pop;
   assign q_pop = adv && !q_stat.empty;

   rep_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (!q_stat.empty),
      .in_item   (head_item),
      .out_valid (trig_valid),
      .out_trig  (trig)
   );

   rep_radius u_radius (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (trig_valid),
      .in_trig    (trig),
      .cfg        (cfg_ff),
      .out_valid  (out_valid),
      .point_x    (rsp_point_x),
      .point_y    (rsp_point_y),
      .degenerate (rsp_degenerate)
   );

   assign rsp_empty = !out_valid;

`ifndef SYNTHESIS
   a_degenerate_zero : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_degenerate) |-> (rsp_point_x == '0 && rsp_point_y == '0))
      else $error("degenerate result with nonzero coordinates");

   a_point_range : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_point_x <= 18'sd65536 && rsp_point_x >= -18'sd65536
                      && rsp_point_y <= 18'sd65536 && rsp_point_y >= -18'sd65536))
      else $error("result coordinate beyond saturation limit");

   a_queue_push : assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("queue written while full");

   a_result_held : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_point_x)
                                    && $stable(rsp_point_y)))
      else $error("waiting result lost before transfer");
`endif

endmodule
